// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check with asynchronous reset disable.
`define FCBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true on a clock edge.
`define FCBA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FCBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCBA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/fcba_pkg.sv =====
// Package for the block allocator: field widths, codes and the sequencer program.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package fcba_pkg;

	// Field and register widths.
	localparam int OP_W      = 2;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int HEAD_W    = 10;
	localparam int FB_W      = 10;
	localparam int STEP_W    = 5;

	// Default table size.
	localparam int DEF_BLOCKS = 1024;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_INODE_START = 11'd107;
	localparam logic [CFG_W-1:0] RST_DATA_START  = 11'd307;
	localparam logic [CFG_W-1:0] RST_TOTAL       = 11'd1024;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INODE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL       = 2'd2;

	// Request codes.
	localparam logic [OP_W-1:0] OP_INODE = 2'd0;
	localparam logic [OP_W-1:0] OP_CHAIN = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	// Datapath actions, one per control word.
	typedef enum logic [3:0] {
		A_NONE,
		A_INODE_INIT,
		A_CHAIN_INIT,
		A_FREE_INIT,
		A_SCAN,
		A_MARK,
		A_LINK,
		A_TAIL,
		A_UNDO,
		A_RELEASE,
		A_DONE_OK,
		A_DONE_FAIL,
		A_DONE_WALK
	} act_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_OP_INODE,
		C_OP_CHAIN,
		C_OP_FREE,
		C_PTR_GE_END,
		C_USED,
		C_LINK_MORE,
		C_WANT_ZERO,
		C_GOT_ZERO,
		C_GOT_LT_WANT,
		C_GOT_EQ_WANT
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	// One control word: action, jump condition and jump target.
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	// Program step addresses.
	localparam step_t S_IDLE   = 5'd0;
	localparam step_t S_DISP   = 5'd1;
	localparam step_t S_DISP1  = 5'd2;
	localparam step_t S_DISP2  = 5'd3;
	localparam step_t S_FAIL   = 5'd4;
	localparam step_t S_OK     = 5'd5;
	localparam step_t S_I_INIT = 5'd6;
	localparam step_t S_I_TEST = 5'd7;
	localparam step_t S_I_SCAN = 5'd8;
	localparam step_t S_I_MARK = 5'd9;
	localparam step_t S_C_INIT = 5'd10;
	localparam step_t S_C_TEST = 5'd11;
	localparam step_t S_C_SCAN = 5'd12;
	localparam step_t S_C_LINK = 5'd13;
	localparam step_t S_C_MORE = 5'd14;
	localparam step_t S_C_END  = 5'd15;
	localparam step_t S_C_UNDO = 5'd16;
	localparam step_t S_W_TEST = 5'd17;
	localparam step_t S_W_REL  = 5'd18;
	localparam step_t S_W_DONE = 5'd19;
	localparam step_t S_F_INIT = 5'd20;

	// Control store. A step that does not jump falls through to the next address.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		begin
			unique case (s)
				S_IDLE:   w = '{A_NONE,       C_NEVER,       S_IDLE};
				S_DISP:   w = '{A_NONE,       C_OP_INODE,    S_I_INIT};
				S_DISP1:  w = '{A_NONE,       C_OP_CHAIN,    S_C_INIT};
				S_DISP2:  w = '{A_NONE,       C_OP_FREE,     S_F_INIT};
				S_FAIL:   w = '{A_DONE_FAIL,  C_ALWAYS,      S_IDLE};
				S_OK:     w = '{A_DONE_OK,    C_ALWAYS,      S_IDLE};
				S_I_INIT: w = '{A_INODE_INIT, C_NEVER,       S_IDLE};
				S_I_TEST: w = '{A_NONE,       C_PTR_GE_END,  S_FAIL};
				S_I_SCAN: w = '{A_SCAN,       C_USED,        S_I_TEST};
				S_I_MARK: w = '{A_MARK,       C_ALWAYS,      S_OK};
				S_C_INIT: w = '{A_CHAIN_INIT, C_WANT_ZERO,   S_FAIL};
				S_C_TEST: w = '{A_NONE,       C_PTR_GE_END,  S_C_END};
				S_C_SCAN: w = '{A_SCAN,       C_USED,        S_C_TEST};
				S_C_LINK: w = '{A_LINK,       C_NEVER,       S_IDLE};
				S_C_MORE: w = '{A_NONE,       C_GOT_LT_WANT, S_C_TEST};
				S_C_END:  w = '{A_TAIL,       C_GOT_EQ_WANT, S_OK};
				S_C_UNDO: w = '{A_UNDO,       C_GOT_ZERO,    S_FAIL};
				S_W_TEST: w = '{A_NONE,       C_PTR_GE_END,  S_W_DONE};
				S_W_REL:  w = '{A_RELEASE,    C_LINK_MORE,   S_W_TEST};
				S_W_DONE: w = '{A_DONE_WALK,  C_ALWAYS,      S_IDLE};
				S_F_INIT: w = '{A_FREE_INIT,  C_ALWAYS,      S_W_TEST};
				default:  w = '{A_NONE,       C_ALWAYS,      S_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== src/fcba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; sized by the WIDTH and DEPTH parameters.
`timescale 1ns / 1ps

module fcba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/fat_chain_block_allocator_unit.sv =====
// Top level of the FAT-style block allocator: sequencer, datapath and block table.
// Depends on fcba_pkg, fcba_ram and assert_macros.svh.
//
// A request is taken when start is high and busy is low; exactly one result follows,
// shown on status and first_block for a single cycle while done is high. The receiver
// cannot stall, so it must capture the result on that cycle. All work runs through the
// one table RAM, whose read data is registered: a scan tests its pointer against the
// region end and then reads the entry, and a chain walk does the same for each block
// it visits. When allocate chain runs out of space it returns the blocks it took by
// walking the partial chain from its head. A zero count or the unused op code ends
// with a failing status. busy drops in the cycle in which done is high, so the next
// request can be taken there. After reset the block runs a clearing pass over every
// table entry, with busy high; configuration writes are taken at any time and should
// only be made while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fat_chain_block_allocator_unit
	import fcba_pkg::*;
#(
	parameter int BLOCKS = DEF_BLOCKS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request beat.
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      op,
	input  logic [CFG_W-1:0]     count,
	input  logic [HEAD_W-1:0]    head,
	// Result beat.
	output logic                 done,
	output logic                 status,
	output logic [FB_W-1:0]      first_block,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Block number width, counter width and table word layout {used, valid, link}.
	localparam int BW        = $clog2(BLOCKS);
	localparam int CW        = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;
	localparam int ROW_W     = BW + 2;
	localparam int USED_BIT  = BW + 1;
	localparam int VALID_BIT = BW;
	localparam logic [CW-1:0] BLOCKS_CW = CW'(BLOCKS);
	localparam logic [BW-1:0] LAST_ROW  = BW'(BLOCKS - 1);

	// Limit a region end to the table size.
	function automatic logic [CW-1:0] clip_end(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ve;
		begin
			ve = CW'(v);
			return (ve > BLOCKS_CW) ? BLOCKS_CW : ve;
		end
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0] inode_start_q;
	logic [CFG_W-1:0] data_start_q;
	logic [CFG_W-1:0] total_q;

	// Sequencer and control state.
	step_t           pc_q;
	uword_t          uw;
	logic            take;
	logic            accept;
	logic            clearing_q;
	logic [BW-1:0]   clr_addr_q;
	logic            done_q;

	// Request and datapath registers.
	logic [OP_W-1:0]   op_q;
	logic [CW-1:0]     want_q;
	logic [HEAD_W-1:0] head_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     end_q;
	logic [CW-1:0]     got_q;
	logic [BW-1:0]     hit_q;
	logic [BW-1:0]     tail_q;
	logic [BW-1:0]     first_q;
	logic [BW:0]       word_q;
	logic              fail_q;
	logic              status_q;
	logic [FB_W-1:0]   first_block_q;

	// Table RAM signals.
	logic             ram_we;
	logic [BW-1:0]    ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	assign uw        = ucode(pc_q);
	assign busy      = clearing_q || (pc_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done        = done_q;
	assign status      = status_q;
	assign first_block = first_block_q;

	// Block table: one word per block.
	fcba_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[BW-1:0]),
		.rdata(ram_rdata)
	);

	// Jump condition of the current step.
	always_comb begin
		unique case (uw.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_OP_INODE:    take = (op_q == OP_INODE);
			C_OP_CHAIN:    take = (op_q == OP_CHAIN);
			C_OP_FREE:     take = (op_q == OP_FREE);
			C_PTR_GE_END:  take = (ptr_q >= end_q);
			C_USED:        take = ram_rdata[USED_BIT];
			C_LINK_MORE:   take = ram_rdata[VALID_BIT];
			C_WANT_ZERO:   take = (want_q == '0);
			C_GOT_ZERO:    take = (got_q == '0);
			C_GOT_LT_WANT: take = (got_q < want_q);
			C_GOT_EQ_WANT: take = (got_q == want_q);
			default:       take = 1'b0;
		endcase
	end

	// Table writes: the clearing pass first, then the action of the current step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[BW-1:0];
		ram_wdata = '0;
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = {(clr_addr_q < BW'(2)), 1'b0, {BW{1'b0}}};
		end else begin
			unique case (uw.act)
				A_MARK: begin
					ram_we    = 1'b1;
					ram_waddr = hit_q;
					ram_wdata = {1'b1, word_q};
				end
				A_LINK: begin
					ram_we    = (got_q != '0);
					ram_waddr = tail_q;
					ram_wdata = {1'b1, 1'b1, hit_q};
				end
				A_TAIL: begin
					ram_we    = (got_q != '0);
					ram_waddr = tail_q;
					ram_wdata = {1'b1, 1'b0, {BW{1'b0}}};
				end
				A_RELEASE: begin
					ram_we    = 1'b1;
					ram_waddr = ptr_q[BW-1:0];
					ram_wdata = '0;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	// Control state: configuration, clearing pass, step counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_start_q <= RST_INODE_START;
			data_start_q  <= RST_DATA_START;
			total_q       <= RST_TOTAL;
			clearing_q    <= 1'b1;
			clr_addr_q    <= '0;
			pc_q          <= S_IDLE;
			done_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_INODE_START: inode_start_q <= cfg_data;
					REG_DATA_START:  data_start_q  <= cfg_data;
					REG_TOTAL:       total_q       <= cfg_data;
					default:         ;
				endcase
			end
			if (clearing_q) begin
				if (clr_addr_q == LAST_ROW) begin
					clearing_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (accept) begin
				pc_q <= S_DISP;
			end else if (pc_q != S_IDLE) begin
				pc_q <= take ? uw.target : pc_q + 1'b1;
			end
			done_q <= (uw.act == A_DONE_OK) || (uw.act == A_DONE_FAIL) ||
				(uw.act == A_DONE_WALK);
		end
	end

	// Datapath: request capture and the action of each step.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			want_q <= CW'(count);
			head_q <= head;
		end
		unique case (uw.act)
			A_INODE_INIT: begin
				ptr_q <= CW'(inode_start_q);
				end_q <= clip_end(data_start_q);
			end
			A_CHAIN_INIT: begin
				ptr_q <= CW'(data_start_q);
				end_q <= clip_end(total_q);
				got_q <= '0;
			end
			A_FREE_INIT: begin
				ptr_q  <= CW'(head_q);
				end_q  <= clip_end(total_q);
				fail_q <= 1'b0;
			end
			// Remember the entry just read and move on to the next one.
			A_SCAN: begin
				hit_q  <= ptr_q[BW-1:0];
				word_q <= ram_rdata[BW:0];
				ptr_q  <= ptr_q + 1'b1;
			end
			A_MARK: begin
				first_q <= hit_q;
			end
			// The previous block of the chain gets its link written this cycle.
			A_LINK: begin
				if (got_q == '0) begin
					first_q <= hit_q;
				end
				tail_q <= hit_q;
				got_q  <= got_q + 1'b1;
			end
			// Return the partial chain by walking it from its head.
			A_UNDO: begin
				ptr_q  <= CW'(first_q);
				fail_q <= 1'b1;
			end
			A_RELEASE: begin
				ptr_q <= CW'(ram_rdata[BW-1:0]);
			end
			A_DONE_OK: begin
				status_q      <= 1'b0;
				first_block_q <= FB_W'(first_q);
			end
			A_DONE_FAIL: begin
				status_q      <= 1'b1;
				first_block_q <= '0;
			end
			A_DONE_WALK: begin
				status_q      <= fail_q;
				first_block_q <= '0;
			end
			default: ;
		endcase
	end

	// Two results never come back to back.
	`FCBA_ASSERT(a_done_single, clk, arst_n, done_q |=> !done_q, "two results back to back")
	// The table is left alone while nothing is in progress.
	`FCBA_NEVER(a_idle_no_write, clk, arst_n,
		(pc_q == S_IDLE) && !clearing_q && ram_we, "table written while idle")
	// A chain walk only releases blocks inside the table.
	`FCBA_NEVER(a_release_range, clk, arst_n,
		(uw.act == A_RELEASE) && (ptr_q >= BLOCKS_CW), "release beyond table end")
	// A new chain never grows past the requested count.
	`FCBA_NEVER(a_chain_count, clk, arst_n,
		(uw.act == A_LINK) && (got_q >= want_q), "chain longer than requested")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for fat_chain_block_allocator_unit: request beats, a table
// predictor and a result checker. Depends on fcba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top
	import fcba_pkg::*;
();

	// Codes the package leaves unnamed.
	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;

	// Cycles with no beat of any kind before the run is declared hung.
	localparam int STALL_LIMIT = 50000;

	typedef struct packed {
		logic            status;
		logic [FB_W-1:0] first_block;
	} alloc_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      op;
	logic [CFG_W-1:0]     count;
	logic [HEAD_W-1:0]    head;
	logic                 done;
	logic                 status;
	logic [FB_W-1:0]      first_block;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predicted block table and register copies.
	bit               blk_used   [DEF_BLOCKS];
	bit               blk_linked [DEF_BLOCKS];
	logic [CFG_W-1:0] blk_next   [DEF_BLOCKS];
	logic [CFG_W-1:0] reg_inode_start;
	logic [CFG_W-1:0] reg_data_start;
	logic [CFG_W-1:0] reg_total;

	alloc_result_t     pending_results[$];
	logic [HEAD_W-1:0] live_heads[$];
	int                idle_pct;
	int                n_fail = 0;
	int                stall_cycles = 0;

	fat_chain_block_allocator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.count       (count),
		.head        (head),
		.done        (done),
		.status      (status),
		.first_block (first_block),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A region end never reaches past the table.
	function automatic int table_end(input logic [CFG_W-1:0] v);
		return (int'(v) > DEF_BLOCKS) ? DEF_BLOCKS : int'(v);
	endfunction

	// Random values for request fields that the operation ignores.
	function automatic logic [CFG_W-1:0] any_count();
		return CFG_W'($urandom);
	endfunction

	function automatic logic [HEAD_W-1:0] any_head();
		return HEAD_W'($urandom);
	endfunction

	function automatic void release_entry(input int b);
		blk_used[b]   = 1'b0;
		blk_linked[b] = 1'b0;
		blk_next[b]   = '0;
	endfunction

	// Applies one request to the predicted table and returns the result it must give.
	function automatic alloc_result_t predict_alloc(input logic [OP_W-1:0] req_op,
			input logic [CFG_W-1:0] req_count, input logic [HEAD_W-1:0] req_head);
		alloc_result_t r;
		int lim, b, nx, n, got, first, prev;
		bit more;
		r.status = 1'b1;
		r.first_block = '0;
		case (req_op)
			OP_INODE: begin
				lim = table_end(reg_data_start);
				for (b = int'(reg_inode_start); b < lim; b++) begin
					if (!blk_used[b]) begin
						blk_used[b] = 1'b1;
						r.status = 1'b0;
						r.first_block = b[FB_W-1:0];
						break;
					end
				end
			end
			OP_CHAIN: begin
				if (req_count != '0) begin
					lim = table_end(reg_total);
					got = 0;
					first = 0;
					prev = 0;
					// First fit over the data region, each new block linked behind the last.
					for (b = int'(reg_data_start); b < lim && got < int'(req_count); b++) begin
						if (!blk_used[b]) begin
							blk_used[b] = 1'b1;
							blk_linked[b] = 1'b0;
							blk_next[b] = '0;
							if (got == 0) begin
								first = b;
							end else begin
								blk_next[prev] = b[CFG_W-1:0];
								blk_linked[prev] = 1'b1;
							end
							prev = b;
							got++;
						end
					end
					if (got == int'(req_count)) begin
						r.status = 1'b0;
						r.first_block = first[FB_W-1:0];
					end else begin
						// Short of space: give back every block just taken.
						b = first;
						for (n = 0; n < got && b < DEF_BLOCKS; n++) begin
							more = blk_linked[b];
							nx = int'(blk_next[b]);
							release_entry(b);
							if (!more)
								break;
							b = nx;
						end
					end
				end
			end
			OP_FREE: begin
				lim = table_end(reg_total);
				b = int'(req_head);
				for (n = 0; n < DEF_BLOCKS && b < lim; n++) begin
					more = blk_linked[b];
					nx = int'(blk_next[b]);
					release_entry(b);
					if (!more)
						break;
					b = nx;
				end
				r.status = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Sends one request beat; called and returning at a falling edge.
	task automatic send_req(input logic [OP_W-1:0] o, input logic [CFG_W-1:0] c,
			input logic [HEAD_W-1:0] h);
		alloc_result_t r;
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		start = 1'b1;
		op = o;
		count = c;
		head = h;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = predict_alloc(o, c, h);
		pending_results.push_back(r);
		if (o == OP_FREE) begin
			for (int i = live_heads.size() - 1; i >= 0; i--)
				if (live_heads[i] == h)
					live_heads.delete(i);
		end else if (r.status == 1'b0) begin
			live_heads.push_back(r.first_block);
		end
		@(negedge clk);
		start = 1'b0;
		op = OP_W'($urandom);
		count = any_count();
		head = any_head();
	endtask

	// Holds off until every result is in and the block is idle.
	task automatic wait_idle();
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_INODE_START: reg_inode_start = val;
			REG_DATA_START:  reg_data_start = val;
			REG_TOTAL:       reg_total = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regions(input logic [CFG_W-1:0] inode_start,
			input logic [CFG_W-1:0] data_start, input logic [CFG_W-1:0] total);
		wait_idle();
		write_reg(REG_INODE_START, inode_start);
		write_reg(REG_DATA_START, data_start);
		write_reg(REG_TOTAL, total);
	endtask

	// Reset regions: first-fit order, reuse of freed blocks, zero and oversize counts.
	task automatic test_default_regions();
		send_req(OP_INODE, any_count(), any_head());
		send_req(OP_INODE, any_count(), any_head());
		send_req(OP_CHAIN, 11'd1, any_head());
		send_req(OP_CHAIN, 11'd3, any_head());
		send_req(OP_CHAIN, 11'd0, any_head());
		send_req(OP_UNUSED, 11'h7FF, 10'h3FF);
		send_req(OP_FREE, any_count(), 10'd308);
		send_req(OP_CHAIN, 11'd2, any_head());
		send_req(OP_CHAIN, 11'h7FF, any_head());
		send_req(OP_CHAIN, 11'd1024, any_head());
		send_req(OP_FREE, any_count(), 10'd107);
		send_req(OP_FREE, any_count(), 10'h3FF);
		send_req(OP_FREE, any_count(), 10'd307);
	endtask

	// Empty and clipped regions, and chain walks cut off at the region end.
	task automatic test_region_edges();
		set_regions(11'd0, 11'd1024, 11'h7FF);
		send_req(OP_INODE, any_count(), any_head());
		send_req(OP_CHAIN, 11'd1, any_head());
		set_regions(11'd5, 11'd5, 11'd0);
		write_reg(REG_NONE, 11'h7FF);
		send_req(OP_INODE, any_count(), any_head());
		send_req(OP_CHAIN, 11'd1, any_head());
		send_req(OP_FREE, any_count(), 10'd0);
		set_regions(RST_INODE_START, 11'd1000, RST_TOTAL);
		send_req(OP_CHAIN, 11'd6, any_head());
		set_regions(RST_INODE_START, 11'd1000, 11'd1003);
		send_req(OP_FREE, any_count(), 10'd1000);
		set_regions(RST_INODE_START, 11'd1000, RST_TOTAL);
		send_req(OP_CHAIN, 11'd3, any_head());
		send_req(OP_FREE, any_count(), 10'd1003);
		set_regions(11'd0, 11'd2, RST_TOTAL);
		send_req(OP_INODE, any_count(), any_head());
		set_regions(11'h7FF, 11'd0, 11'h7FF);
		send_req(OP_CHAIN, 11'd2, any_head());
		send_req(OP_FREE, any_count(), live_heads[live_heads.size() - 1]);
	endtask

	// Mostly allocate-then-free traffic over several region layouts and idle rates.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] a, b, c;
		logic [HEAD_W-1:0] h;
		int sel, idx;
		for (int seg = 0; seg < 6; seg++) begin
			idle_pct = (seg < 2) ? 23 : (seg < 4) ? 63 : 0;
			case (seg)
				0: begin a = RST_INODE_START; b = RST_DATA_START; c = RST_TOTAL; end
				1: begin a = 11'd2; b = 11'd20; c = 11'd90; end
				3: begin a = 11'd0; b = 11'd512; c = 11'h7FF; end
				4: begin a = 11'd960; b = 11'd980; c = RST_TOTAL; end
				default: begin
					a = CFG_W'($urandom_range(0, 400));
					b = a + CFG_W'($urandom_range(0, 300));
					c = b + CFG_W'($urandom_range(0, 1300));
				end
			endcase
			set_regions(a, b, c);
			repeat (92) begin
				sel = $urandom_range(99);
				if (sel < 35) begin
					if ($urandom_range(9) == 0)
						c = CFG_W'($urandom_range(9, 64));
					else
						c = CFG_W'($urandom_range(1, 8));
					send_req(OP_CHAIN, c, any_head());
				end else if (sel < 38) begin
					send_req(OP_CHAIN, CFG_W'($urandom_range(1024, 2047)), any_head());
				end else if (sel < 40) begin
					send_req(OP_CHAIN, 11'd0, any_head());
				end else if (sel < 55) begin
					send_req(OP_INODE, any_count(), any_head());
				end else if (sel < 88) begin
					// Free a head that an earlier beat handed out, if any is left.
					if (live_heads.size() != 0) begin
						idx = $urandom_range(live_heads.size() - 1);
						h = live_heads[idx];
					end else begin
						h = any_head();
					end
					send_req(OP_FREE, any_count(), h);
				end else if (sel < 95) begin
					send_req(OP_FREE, any_count(), any_head());
				end else begin
					send_req(OP_UNUSED, any_count(), any_head());
				end
				if ($urandom_range(39) == 0)
					wait_idle();
			end
		end
	endtask

	// Each result beat is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: status %0d first_block %0d",
					status, first_block);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, status);
					n_fail++;
				end
				if (first_block !== want.first_block) begin
					$error("first_block: expected %0d actual %0d", want.first_block, first_block);
					n_fail++;
				end
			end
		end
	end

	// Ends the run when no beat of any kind moves for too long.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;
		count = '0;
		head = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 23;
		reg_inode_start = RST_INODE_START;
		reg_data_start = RST_DATA_START;
		reg_total = RST_TOTAL;
		for (int i = 0; i < DEF_BLOCKS; i++) begin
			blk_used[i] = (i < 2);
			blk_linked[i] = 1'b0;
			blk_next[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_default_regions();
		test_region_edges();
		test_random_traffic();

		wait_idle();
		repeat (20) @(negedge clk);
		if (pending_results.size() != 0)
			$error("%0d results never arrived", pending_results.size());
		if (n_fail == 0 && pending_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
